>>> hw/rtl/lacs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lacs_pkg: shared types and constants for the level alarm block
// Field widths, class codes, register indexes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lacs_pkg;

	localparam int LEVEL_W = 10;
	localparam int TREND_W = 3;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 32;
	localparam int CLASS_W = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int ACC_W = LEVEL_W + COUNT_W;
	localparam int DIV_STEPS = LEVEL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [LEVEL_W-1:0] LOW_THR_RST  = LEVEL_W'(70);
	localparam logic [LEVEL_W-1:0] CRIT_THR_RST = LEVEL_W'(54);
	localparam logic [LEVEL_W-1:0] HIGH_THR_RST = LEVEL_W'(250);
	localparam logic [TIME_W-1:0]  CRIT_COOL_RST = TIME_W'(300000);
	localparam logic [TIME_W-1:0]  NORM_COOL_RST = TIME_W'(1800000);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [CLASS_W-1:0] {
		CLS_NONE     = 2'd0,
		CLS_LOW      = 2'd1,
		CLS_CRITICAL = 2'd2,
		CLS_HIGH     = 2'd3
	} class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_THR   = 3'd0,
		REG_CRIT_THR  = 3'd1,
		REG_HIGH_THR  = 3'd2,
		REG_ALERTS_ON = 3'd3,
		REG_CRIT_COOL = 3'd4,
		REG_NORM_COOL = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_PREP,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic prep;
		logic step;
		logic write;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lacs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lacs_if: reading and result channels of the level alarm block
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lacs_in_if import lacs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level_value;
	logic [TREND_W-1:0] trend_code;
	logic [TIME_W-1:0]  now_ms;

	modport source(output valid, level_value, trend_code, now_ms, input ready);
	modport sink(input valid, level_value, trend_code, now_ms, output ready);
endinterface

interface lacs_out_if import lacs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] alert_class;
	logic               alert_fired;
	logic [COUNT_W-1:0] reading_count;
	logic [COUNT_W-1:0] low_count;
	logic [COUNT_W-1:0] high_count;
	logic [COUNT_W-1:0] alerting_count;
	logic [LEVEL_W-1:0] mean_level;
	logic [LEVEL_W-1:0] alerted_level;
	logic [TREND_W-1:0] alerted_trend;

	modport source(output valid, alert_class, alert_fired, reading_count, low_count,
		high_count, alerting_count, mean_level, alerted_level, alerted_trend,
		input ready);
	modport sink(input valid, alert_class, alert_fired, reading_count, low_count,
		high_count, alerting_count, mean_level, alerted_level, alerted_trend,
		output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lacs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lacs_ctrl: sequencer for the level alarm block
// Steps one reading through capture, multiply, setup, serial divide and
// result write-back.
// ----------------------------------------------------------------------------
module lacs_ctrl import lacs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd
);

	state_t                state_q, state_nxt;
	logic [DIV_CNT_W-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.prep) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc  = 1'b1;
				state_nxt = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_nxt = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (stat.out_free) begin
					cmd.write = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/lacs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lacs_dp: datapath of the level alarm block
// Configuration registers, classification, saturating counters, alert
// state, the running-mean multiply and restoring divide, result register.
// ----------------------------------------------------------------------------
module lacs_dp import lacs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [LEVEL_W-1:0]    level_value,
	input  wire logic [TREND_W-1:0]    trend_code,
	input  wire logic [TIME_W-1:0]     now_ms,
	input  wire ctrl_cmd_t             cmd,
	output dp_stat_t                   stat,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [CLASS_W-1:0]         alert_class,
	output logic                       alert_fired,
	output logic [COUNT_W-1:0]         reading_count,
	output logic [COUNT_W-1:0]         low_count,
	output logic [COUNT_W-1:0]         high_count,
	output logic [COUNT_W-1:0]         alerting_count,
	output logic [LEVEL_W-1:0]         mean_level,
	output logic [LEVEL_W-1:0]         alerted_level,
	output logic [TREND_W-1:0]         alerted_trend
);

	logic [LEVEL_W-1:0] low_thr_q, crit_thr_q, high_thr_q;
	logic               alerts_on_q;
	logic [TIME_W-1:0]  crit_cool_q, norm_cool_q;

	logic [LEVEL_W-1:0] level_q;
	logic [TREND_W-1:0] trend_q;
	logic [TIME_W-1:0]  now_q;
	class_t             cls_q, prev_cls_q, cls_in;

	logic [COUNT_W-1:0] total_q, below_q, above_q, flagged_q;
	logic [LEVEL_W-1:0] mean_q;
	logic [TIME_W-1:0]  prev_time_q;
	logic [LEVEL_W-1:0] saved_level_q;
	logic [TREND_W-1:0] saved_trend_q;
	logic               fired_q;

	logic [ACC_W-1:0]   prod_q;
	logic [TIME_W-1:0]  gap_q;
	logic [COUNT_W-1:0] rem_q;
	logic [LEVEL_W-1:0] quo_q;
	logic               out_valid_q;

	logic [ACC_W-1:0]   acc;
	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   trial_diff;
	logic               trial_ge;
	logic [TIME_W-1:0]  cool;
	logic               fire;

	// Critical wins over low, low over high.
	always_comb begin
		if (level_value < crit_thr_q) begin
			cls_in = CLS_CRITICAL;
		end else if (level_value < low_thr_q) begin
			cls_in = CLS_LOW;
		end else if (level_value > high_thr_q) begin
			cls_in = CLS_HIGH;
		end else begin
			cls_in = CLS_NONE;
		end
	end

	assign acc        = prod_q + ACC_W'(level_q);
	assign trial      = {rem_q, quo_q[LEVEL_W-1]};
	assign trial_diff = trial - {1'b0, total_q};
	assign trial_ge   = !trial_diff[COUNT_W];
	assign cool       = (cls_q == CLS_CRITICAL) ? crit_cool_q : norm_cool_q;
	assign fire       = alerts_on_q && (cls_q != CLS_NONE) &&
		((cls_q != prev_cls_q) || (gap_q > cool));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q   <= LOW_THR_RST;
			crit_thr_q  <= CRIT_THR_RST;
			high_thr_q  <= HIGH_THR_RST;
			alerts_on_q <= 1'b1;
			crit_cool_q <= CRIT_COOL_RST;
			norm_cool_q <= NORM_COOL_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_LOW_THR:   low_thr_q   <= cfg_data[LEVEL_W-1:0];
				REG_CRIT_THR:  crit_thr_q  <= cfg_data[LEVEL_W-1:0];
				REG_HIGH_THR:  high_thr_q  <= cfg_data[LEVEL_W-1:0];
				REG_ALERTS_ON: alerts_on_q <= cfg_data[0];
				REG_CRIT_COOL: crit_cool_q <= cfg_data[TIME_W-1:0];
				REG_NORM_COOL: norm_cool_q <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= '0;
			below_q       <= '0;
			above_q       <= '0;
			flagged_q     <= '0;
			mean_q        <= '0;
			prev_cls_q    <= CLS_NONE;
			prev_time_q   <= '0;
			saved_level_q <= '0;
			saved_trend_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				total_q <= sat_inc(total_q);
				if (level_value < low_thr_q) begin
					below_q <= sat_inc(below_q);
				end
				if (level_value > high_thr_q) begin
					above_q <= sat_inc(above_q);
				end
				if (cls_in != CLS_NONE) begin
					flagged_q <= sat_inc(flagged_q);
				end
			end
			if (cmd.prep && fire) begin
				prev_cls_q    <= cls_q;
				prev_time_q   <= now_q;
				saved_level_q <= level_q;
				saved_trend_q <= trend_q;
			end
			if (cmd.write) begin
				mean_q      <= quo_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of one reading.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			level_q <= level_value;
			trend_q <= trend_code;
			now_q   <= now_ms;
			cls_q   <= cls_in;
		end
		if (cmd.calc) begin
			// On the first reading n - 1 is zero and the divide returns the level.
			prod_q <= ACC_W'(mean_q) * ACC_W'(total_q - COUNT_W'(1));
			gap_q  <= now_q - prev_time_q;
		end
		if (cmd.prep) begin
			fired_q <= fire;
			rem_q   <= acc[ACC_W-1:LEVEL_W];
			quo_q   <= acc[LEVEL_W-1:0];
		end
		if (cmd.step) begin
			rem_q <= trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			quo_q <= {quo_q[LEVEL_W-2:0], trial_ge};
		end
		if (cmd.write) begin
			alert_class    <= cls_q;
			alert_fired    <= fired_q;
			reading_count  <= total_q;
			low_count      <= below_q;
			high_count     <= above_q;
			alerting_count <= flagged_q;
			mean_level     <= quo_q;
			alerted_level  <= saved_level_q;
			alerted_trend  <= saved_trend_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

>>> hw/rtl/level_alarm_cooldown_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// level_alarm_cooldown_stats: level alarm with cooldown and running stats
// Classifies each reading against three thresholds, decides whether an
// alert fires under a critical or normal cooldown, and keeps saturating
// counts and a truncating running mean of the level.
//
//   Channel   Dir   Handshake          Beat contents
//   reading   in    valid / ready      level_value, trend_code, now_ms
//   result    out   valid / ready      class, fired flag, counts, mean, alert
//   cfg       in    cfg_we (no wait)   cfg_index, cfg_data
//
// After the accepting edge a reading passes through the multiply step for
// the 10x32 mean product and the time gap, the setup step for the
// accumulate and alert decision, the restoring divider that forms the ten
// mean bits, then the write into the result register. The next reading
// can be taken in the cycle after the write, so the block takes no new
// reading before the previous one is written. A new reading
// is taken once the previous one has been written, even while its result
// still waits downstream; a stalled result only holds the block in its
// write step. Reset is asynchronous and brings the configuration, counters,
// alert state and out_valid to defaults; working and result data are not.
// ----------------------------------------------------------------------------
module level_alarm_cooldown_stats import lacs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	lacs_in_if.sink                    reading,
	lacs_out_if.source                 result
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// The sequencer decides when a beat is taken and which datapath step runs.
	lacs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (reading.valid),
		.in_ready (reading.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds all configuration, statistics and the result register.
	lacs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.level_value    (reading.level_value),
		.trend_code     (reading.trend_code),
		.now_ms         (reading.now_ms),
		.cmd            (cmd),
		.stat           (stat),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.alert_class    (result.alert_class),
		.alert_fired    (result.alert_fired),
		.reading_count  (result.reading_count),
		.low_count      (result.low_count),
		.high_count     (result.high_count),
		.alerting_count (result.alerting_count),
		.mean_level     (result.mean_level),
		.alerted_level  (result.alerted_level),
		.alerted_trend  (result.alerted_trend)
	);

	// Only one reading is in flight: no beat right after one was taken.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		reading.valid && reading.ready |=> !reading.ready)
		else $error("reading accepted while another is in flight");

	// The result register is only loaded when it is empty or being drained.
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> stat.out_free)
		else $error("result written over a pending beat");

	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> result.valid)
		else $error("result write did not raise valid");

	a_load_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.calc)
		else $error("capture not followed by the multiply step");

	a_prep_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prep |=> cmd.step)
		else $error("divider did not start after setup");

endmodule
`default_nettype wire
